FILE: sv/encoder_axis_position_drive_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the encoder axis position drive unit
// Clocked, reset-qualified property shorthands used by the checker.
// ---------------------------------------------------------------------------
`ifndef ENCODER_AXIS_POSITION_DRIVE_UNIT_MACROS_SVH
`define ENCODER_AXIS_POSITION_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define EPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define EPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/epd_pkg.sv
// ---------------------------------------------------------------------------
// Encoder axis position drive package
// Shared codes, widths and item types for the axis position drive unit.
// ---------------------------------------------------------------------------
package epd_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned LevelW = 7;

  // Input operation selector
  typedef enum logic [1:0] {
    FUNC_SENSOR = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_INIT   = 2'd2
  } func_e;

  // Direction of travel
  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  // Latched bound fault
  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_BELOW = 2'd1,
    FAULT_ABOVE = 2'd2
  } fault_e;

  // Configuration register indexes
  typedef enum logic {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_e;

  localparam logic signed [PosW-1:0] LowerBoundRst = -16'sd4000;
  localparam logic signed [PosW-1:0] UpperBoundRst = 16'sd4000;

  // Drive levels by distance to target
  localparam logic [LevelW-1:0] LevelNear = 7'd75;
  localparam logic [LevelW-1:0] LevelMid  = 7'd80;
  localparam logic [LevelW-1:0] LevelFar  = 7'd90;
  localparam logic [LevelW-1:0] LevelMax  = 7'd100;
  localparam logic [LevelW-1:0] LevelOff  = 7'd0;

  localparam logic [PosW:0] DistNear = 17'd10;
  localparam logic [PosW:0] DistMid  = 17'd25;
  localparam logic [PosW:0] DistFar  = 17'd100;

  typedef struct packed {
    func_e                   func;
    logic [1:0]              sensor_code;
    logic signed [PosW-1:0]  value;
  } item_t;

  typedef struct packed {
    fault_e                  fault;
    dir_e                    moving;
    logic signed [PosW-1:0]  position;
    logic [LevelW-1:0]       drive_right;
    logic [LevelW-1:0]       drive_left;
  } result_t;

endpackage

FILE: sv/encoder_axis_position_drive_unit.sv
// ---------------------------------------------------------------------------
// Encoder axis position drive unit
// Quadrature-tracked DC-motor axis with bound faults and distance-based drive.
// ---------------------------------------------------------------------------
// Path: an input transfer is captured in the input register; its result moves
//   to the result register once that is free, then waits there to transfer.
// Throughput: one item per cycle without stalls; a single pass of state logic.
// Reset: rst_ni clears the axis state, drops both valid flags and restores
//   the bounds to -4000 and 4000.
module encoder_axis_position_drive_unit import epd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] sensor_code, [17:2] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [6:0] drive_left, [13:7] drive_right,
                                      // [29:14] position, [31:30] moving,
                                      // [33:32] fault
);

  logic signed [PosW-1:0] lower_q, upper_q;
  logic                   in_valid_q, in_valid_d;
  item_t                  in_item_q;
  logic                   s_xfer, advance, out_ready;
  result_t                core_res, out_res;

  // Bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerBoundRst;
      upper_q <= UpperBoundRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_LOWER: lower_q <= cfg_wdata_i;
        REG_UPPER: upper_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register handshake
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture input payload
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_item_q <= '{func: func_e'(s_axis_tuser), sensor_code: s_axis_tdata[1:0],
                     value: s_axis_tdata[17:2]};
    end
  end

  epd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_item_q),
    .lower_i  (lower_q),
    .upper_i  (upper_q),
    .result_o (core_res)
  );

  epd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (core_res),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .taken_i  (m_axis_tready),
    .result_o (out_res)
  );

  // Pack result fields, drive_left in the lowest bits
  assign m_axis_tdata = {6'd0, out_res.fault, out_res.moving, out_res.position,
                         out_res.drive_right, out_res.drive_left};

endmodule

FILE: sv/epd_core.sv
// ---------------------------------------------------------------------------
// Axis position drive core
// Holds the axis state and computes next state, one item per cycle with en_i.
// ---------------------------------------------------------------------------
module epd_core import epd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  item_t                  item_i,
  input  logic signed [PosW-1:0] lower_i,
  input  logic signed [PosW-1:0] upper_i,
  output result_t                result_o
);

  typedef struct packed {
    dir_e              dir;
    logic [LevelW-1:0] left;
    logic [LevelW-1:0] right;
  } drive_t;

  // Pick drive level from distance and settle direction
  function automatic drive_t drive_update(dir_e dir, logic signed [PosW-1:0] pos,
                                          logic signed [PosW-1:0] goal);
    logic signed [PosW:0] diff;
    logic [PosW:0]        mag;
    logic [LevelW-1:0]    level;
    drive_t               res;
    diff = {goal[PosW-1], goal} - {pos[PosW-1], pos};
    mag  = diff[PosW] ? 17'(-diff) : 17'(diff);
    if (mag < DistNear) begin
      level = LevelNear;
    end else if (mag < DistMid) begin
      level = LevelMid;
    end else if (mag < DistFar) begin
      level = LevelFar;
    end else begin
      level = LevelMax;
    end
    if (dir == DIR_LEFT && pos > goal) begin
      res = '{dir: DIR_LEFT, left: level, right: LevelOff};
    end else if (dir == DIR_RIGHT && pos < goal) begin
      res = '{dir: DIR_RIGHT, left: LevelOff, right: level};
    end else begin
      res = '{dir: DIR_IDLE, left: LevelOff, right: LevelOff};
    end
    return res;
  endfunction

  logic [1:0]             last_code_q, last_code_d;
  logic signed [PosW-1:0] track_q, track_d;
  logic signed [PosW-1:0] goal_q, goal_d;
  dir_e                   dir_q, dir_d;
  logic [LevelW-1:0]      left_q, left_d;
  logic [LevelW-1:0]      right_q, right_d;
  fault_e                 fault_q, fault_d;

  logic [1:0]             delta;
  logic signed [PosW:0]   step_pos;
  logic signed [PosW-1:0] sat_pos;
  logic signed [PosW:0]   lo_ext, hi_ext;
  logic                   below, above;
  dir_e                   tgt_dir;
  drive_t                 sns_drv, tgt_drv;

  // Step position and check bounds at full precision
  assign delta    = item_i.sensor_code - last_code_q;
  assign step_pos = {track_q[PosW-1], track_q} + ((delta == 2'd1) ? 17'sd1 : -17'sd1);
  assign sat_pos  = (step_pos[PosW] != step_pos[PosW-1])
                    ? {step_pos[PosW], {(PosW-1){~step_pos[PosW]}}}
                    : step_pos[PosW-1:0];
  assign lo_ext   = {lower_i[PosW-1], lower_i};
  assign hi_ext   = {upper_i[PosW-1], upper_i};
  assign below    = step_pos < lo_ext;
  assign above    = step_pos > hi_ext;

  assign tgt_dir  = (track_q > item_i.value) ? DIR_LEFT :
                    (track_q < item_i.value) ? DIR_RIGHT : DIR_IDLE;
  assign sns_drv  = drive_update(dir_q, sat_pos, goal_q);
  assign tgt_drv  = drive_update(tgt_dir, track_q, item_i.value);

  // Next state for the item at hand; a latched fault freezes everything
  always_comb begin
    last_code_d = last_code_q;
    track_d     = track_q;
    goal_d      = goal_q;
    dir_d       = dir_q;
    left_d      = left_q;
    right_d     = right_q;
    fault_d     = fault_q;
    if (fault_q == FAULT_NONE) begin
      unique case (item_i.func)
        FUNC_SENSOR: begin
          track_d = sat_pos;
          if (below || above) begin
            fault_d = below ? FAULT_BELOW : FAULT_ABOVE;
            dir_d   = DIR_IDLE;
            left_d  = LevelOff;
            right_d = LevelOff;
          end else begin
            dir_d       = sns_drv.dir;
            left_d      = sns_drv.left;
            right_d     = sns_drv.right;
            last_code_d = item_i.sensor_code;
          end
        end
        FUNC_TARGET: begin
          goal_d  = item_i.value;
          dir_d   = tgt_drv.dir;
          left_d  = tgt_drv.left;
          right_d = tgt_drv.right;
        end
        FUNC_INIT: begin
          track_d = item_i.value;
        end
        default: begin
        end
      endcase
    end
  end

  // Commit state on each advancing item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_code_q <= 2'd0;
      track_q     <= '0;
      goal_q      <= '0;
      dir_q       <= DIR_IDLE;
      left_q      <= LevelOff;
      right_q     <= LevelOff;
      fault_q     <= FAULT_NONE;
    end else if (en_i) begin
      last_code_q <= last_code_d;
      track_q     <= track_d;
      goal_q      <= goal_d;
      dir_q       <= dir_d;
      left_q      <= left_d;
      right_q     <= right_d;
      fault_q     <= fault_d;
    end
  end

  assign result_o = '{fault: fault_d, moving: dir_d, position: track_d,
                      drive_right: right_d, drive_left: left_d};

endmodule

FILE: sv/epd_out_reg.sv
// ---------------------------------------------------------------------------
// Axis position drive result register
// Holds one result until the downstream side takes the transfer.
// ---------------------------------------------------------------------------
module epd_out_reg import epd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    taken_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  // Free when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || taken_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (taken_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: sv/epd_checker.sv
// ---------------------------------------------------------------------------
// Axis position drive port checker
// Watches the top-level ports for handshake and drive consistency.
// ---------------------------------------------------------------------------
`include "encoder_axis_position_drive_unit_macros.svh"

module epd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [6:0] drv_left, drv_right;
  logic [1:0] moving, fault;

  assign drv_left  = m_axis_tdata[6:0];
  assign drv_right = m_axis_tdata[13:7];
  assign moving    = m_axis_tdata[31:30];
  assign fault     = m_axis_tdata[33:32];

  // Hold a stalled result
  `EPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Accept input whenever no result is pending
  `EPD_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Never drive both ways
  `EPD_ASSERT_NOW(a_one_drive, m_axis_tvalid, drv_left == 7'd0 || drv_right == 7'd0, "both drives on")

  // Fault or idle means drives off
  `EPD_ASSERT_NOW(a_idle_off, m_axis_tvalid && (fault != 2'd0 || moving == 2'd0), drv_left == 7'd0 && drv_right == 7'd0, "drive on while idle or faulted")

  // Left direction means only the left drive is on
  `EPD_ASSERT_NOW(a_dir_match, m_axis_tvalid && moving == 2'd1, drv_left != 7'd0 && drv_right == 7'd0, "left move without left drive")

endmodule

bind encoder_axis_position_drive_unit epd_checker u_epd_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Encoder axis position drive unit testbench
// Drives sensor events and commands into the input stream, with random gaps
// on both sides. A local model of the axis works out the status word that
// each transfer should produce, and the monitor compares every returned
// status with the oldest expected one, field by field. The bounds are
// reprogrammed between phases, and a bound fault is tripped at the end.
// ---------------------------------------------------------------------------
module testbench;
  import epd_pkg::*;

  localparam int         PosMax      = 2 ** (PosW - 1) - 1;
  localparam int         PosMin      = -(2 ** (PosW - 1));
  localparam logic [1:0] FuncUnused  = 2'd3;
  localparam int         StallLimit  = 2000;
  localparam int         DrainCycles = 4;
  localparam int         RandomItems = 1650;
  localparam int         NumWindows  = 7;

  // Ways of tripping the bound fault at the end of the run
  typedef enum int {
    TRIP_BELOW,
    TRIP_ABOVE,
    TRIP_CROSSED,
    TRIP_TOP_EDGE,
    TRIP_BOTTOM_EDGE
  } trip_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [1:0] sensor_code, [17:2] value
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [6:0] drive_left, [13:7] drive_right,
                               // [29:14] position, [31:30] moving, [33:32] fault

  // Axis model state
  logic [1:0]        prev_code;
  int                track;
  int                goal;
  int                bound_lo;
  int                bound_hi;
  dir_e              heading;
  logic [LevelW-1:0] left_lvl;
  logic [LevelW-1:0] right_lvl;
  fault_e            latched;

  result_t axis_status_q[$];
  int      items_sent;
  int      error_cnt;
  int      send_burst;
  int      quiet_cycles;

  encoder_axis_position_drive_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void report_error(string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // Pick the drive level from the distance to the goal, or drop to idle
  function automatic void refresh_drive();
    int                span;
    logic [LevelW-1:0] lvl;
    span = goal - track;
    if (span < 0) span = -span;
    if (span < int'(DistNear)) lvl = LevelNear;
    else if (span < int'(DistMid)) lvl = LevelMid;
    else if (span < int'(DistFar)) lvl = LevelFar;
    else lvl = LevelMax;
    if (heading == DIR_LEFT && track > goal) begin
      left_lvl  = lvl;
      right_lvl = LevelOff;
    end else if (heading == DIR_RIGHT && track < goal) begin
      right_lvl = lvl;
      left_lvl  = LevelOff;
    end else begin
      left_lvl  = LevelOff;
      right_lvl = LevelOff;
      heading   = DIR_IDLE;
    end
  endfunction

  // Advance the axis model by one accepted transfer and queue its status
  function automatic void predict_axis_step(logic [1:0] op, logic [1:0] code,
                                            logic signed [PosW-1:0] val);
    logic [1:0] delta;
    int         nxt;
    result_t    status;
    if (latched == FAULT_NONE) begin
      case (op)
        FUNC_SENSOR: begin
          delta = code - prev_code;
          nxt   = (delta == 2'd1) ? track + 1 : track - 1;
          track = (nxt > PosMax) ? PosMax : ((nxt < PosMin) ? PosMin : nxt);
          // bounds see the unsaturated step; below wins when both fail
          if (nxt < bound_lo || nxt > bound_hi) begin
            latched   = (nxt < bound_lo) ? FAULT_BELOW : FAULT_ABOVE;
            left_lvl  = LevelOff;
            right_lvl = LevelOff;
            heading   = DIR_IDLE;
          end else begin
            refresh_drive();
            prev_code = code;
          end
        end
        FUNC_TARGET: begin
          goal = int'(val);
          if (track > goal) begin
            heading = DIR_LEFT;
            refresh_drive();
          end else if (track < goal) begin
            heading = DIR_RIGHT;
            refresh_drive();
          end else begin
            heading   = DIR_IDLE;
            left_lvl  = LevelOff;
            right_lvl = LevelOff;
          end
        end
        FUNC_INIT: track = int'(val);
        default: ;
      endcase
    end
    status.drive_left  = left_lvl;
    status.drive_right = right_lvl;
    status.position    = PosW'(track);
    status.moving      = heading;
    status.fault       = latched;
    axis_status_q.push_back(status);
  endfunction

  // Send one item on the input stream and update the model once it transfers
  task automatic send_item(logic [1:0] op, logic [1:0] code, logic [PosW-1:0] val);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) == 0) send_burst = $urandom_range(20, 80);
      gap = pick_idle_len();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, val, code};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_axis_step(op, code, val);
    if (op != FuncUnused) items_sent++;
  endtask

  // Sensor event that moves the count one step, with no bound guard
  task automatic step_raw(bit go_up);
    logic [1:0] code;
    if (go_up) begin
      code = prev_code + 2'd1;
    end else begin
      case ($urandom_range(0, 2))
        0: code = prev_code;
        1: code = prev_code + 2'd2;
        default: code = prev_code + 2'd3;
      endcase
    end
    send_item(FUNC_SENSOR, code, 16'($urandom));
  endtask

  function automatic logic [PosW-1:0] inside_window();
    return PosW'(bound_lo + 1 + int'($urandom_range(bound_hi - bound_lo - 2)));
  endfunction

  // Step the way asked if that stays inside the bounds; otherwise take the
  // other way, or re-initialize when no step is safe
  task automatic step_axis(bit want_up);
    bit up_ok;
    bit dn_ok;
    up_ok = (track + 1 <= bound_hi) && (track + 1 >= bound_lo);
    dn_ok = (track - 1 >= bound_lo) && (track - 1 <= bound_hi);
    if (!up_ok && !dn_ok) send_item(FUNC_INIT, 2'($urandom), inside_window());
    else step_raw(want_up ? up_ok : !dn_ok);
  endtask

  // Drop valid and wait until every status has come back
  task automatic quiesce_axis();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (axis_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_bound(reg_e idx, logic [PosW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LOWER) bound_lo = int'(signed'(val));
    else bound_hi = int'(signed'(val));
  endtask

  // Quadrature decoding, every drive level, reaching and passing the goal
  task automatic test_quadrature_steps();
    send_item(FuncUnused, 2'd3, 16'h7FFF);
    send_item(FUNC_SENSOR, 2'd0, 16'h8000);   // same code counts down
    send_item(FUNC_SENSOR, 2'd1, 16'hFFFF);   // +1 counts up
    send_item(FUNC_SENSOR, 2'd3, 16'h0000);   // change of two counts down
    send_item(FUNC_SENSOR, 2'd0, 16'h5555);   // wrap from 3 to 0 counts up
    send_item(FUNC_SENSOR, 2'd3, 16'hAAAA);   // -1 counts down
    send_item(FUNC_TARGET, 2'd0, -16'sd1);    // goal equal to position
    send_item(FUNC_TARGET, 2'd2, 16'sd200);
    send_item(FUNC_INIT, 2'd1, 16'sd150);     // no drive update on init
    step_axis(1'b1);
    send_item(FUNC_INIT, 2'd0, 16'sd185);
    step_axis(1'b1);
    send_item(FUNC_INIT, 2'd0, 16'sd194);
    step_axis(1'b1);
    send_item(FUNC_INIT, 2'd0, 16'sd198);
    step_axis(1'b1);
    step_axis(1'b1);                          // reach the goal
    send_item(FUNC_TARGET, 2'd3, 16'h8000);
    step_axis(1'b0);
    send_item(FUNC_TARGET, 2'd1, 16'h7FFF);
    send_item(FUNC_TARGET, 2'd0, 16'sd5);
    send_item(FUNC_INIT, 2'd0, 16'sd2);
    send_item(FUNC_TARGET, 2'd0, 16'sd5);
    send_item(FUNC_INIT, 2'd0, 16'sd10);
    step_axis(1'b1);                          // pass the goal
  endtask

  // Full-range bounds with the position at both ends of its range
  task automatic test_range_extremes();
    quiesce_axis();
    write_bound(REG_LOWER, PosW'(PosMin));
    write_bound(REG_UPPER, PosW'(PosMax));
    send_item(FUNC_INIT, 2'd0, PosW'(PosMax));
    step_axis(1'b0);
    step_axis(1'b1);
    send_item(FUNC_TARGET, 2'd0, PosW'(PosMin));
    step_axis(1'b0);
    send_item(FUNC_INIT, 2'd0, PosW'(PosMin));
    step_axis(1'b1);
    step_axis(1'b0);
    send_item(FUNC_TARGET, 2'd0, PosW'(PosMin));
    send_item(FUNC_TARGET, 2'd0, PosW'(PosMax));
  endtask

  // One move: set a goal, then step mostly toward it with some noise;
  // stop early once the item budget of the window is used up
  task automatic run_move_sequence(int stop_at);
    int goal_pick;
    int n_steps;
    int r;
    if ($urandom_range(0, 4) != 0) begin
      goal_pick = track + int'($urandom_range(300)) - 150;
      if (goal_pick < bound_lo) goal_pick = bound_lo;
      if (goal_pick > bound_hi) goal_pick = bound_hi;
    end else begin
      goal_pick = int'($urandom_range(65535)) + PosMin;
    end
    send_item(FUNC_TARGET, 2'($urandom), PosW'(goal_pick));
    n_steps = $urandom_range(10, 220);
    repeat (n_steps) begin
      if (items_sent >= stop_at) break;
      r = $urandom_range(0, 99);
      if (r < 4) send_item(FUNC_INIT, 2'($urandom), inside_window());
      else if (r < 6) send_item(FuncUnused, 2'($urandom), 16'($urandom));
      else if (r < 8) send_item(FUNC_TARGET, 2'($urandom), 16'($urandom));
      else if (r < 90) step_axis(goal > track);
      else step_axis(goal <= track);
      if (heading == DIR_IDLE && $urandom_range(0, 3) == 0) break;
    end
  endtask

  // Random moves inside a series of bound windows
  task automatic test_random_motion();
    int lo;
    int hi;
    int stop_at;
    for (int k = 0; k < NumWindows; k++) begin
      case (k)
        0: begin lo = -4000;  hi = 4000;   end
        1: begin lo = -50;    hi = 50;     end
        2: begin lo = -1;     hi = 1;      end
        3: begin lo = 100;    hi = 600;    end
        4: begin lo = PosMin; hi = PosMax; end
        5: begin lo = 32000;  hi = PosMax; end
        default: begin lo = PosMin; hi = -32000; end
      endcase
      quiesce_axis();
      write_bound(REG_LOWER, PosW'(lo));
      write_bound(REG_UPPER, PosW'(hi));
      stop_at = items_sent + RandomItems / NumWindows;
      while (items_sent < stop_at) run_move_sequence(stop_at);
    end
  endtask

  // Trip a bound fault, then check that nothing moves the axis any more
  task automatic test_fault_freeze();
    trip_e trip;
    trip = trip_e'($urandom_range(0, 4));
    quiesce_axis();
    case (trip)
      TRIP_BELOW, TRIP_ABOVE: begin
        write_bound(REG_LOWER, -16'sd20);
        write_bound(REG_UPPER, 16'sd20);
      end
      TRIP_CROSSED: begin
        write_bound(REG_LOWER, 16'sd10);
        write_bound(REG_UPPER, -16'sd10);
      end
      default: begin
        write_bound(REG_LOWER, PosW'(PosMin));
        write_bound(REG_UPPER, PosW'(PosMax));
      end
    endcase
    case (trip)
      TRIP_BELOW: begin
        send_item(FUNC_INIT, 2'd0, -16'sd18);
        send_item(FUNC_TARGET, 2'd0, -16'sd100);
        repeat (4) step_raw(1'b0);
      end
      TRIP_ABOVE: begin
        send_item(FUNC_INIT, 2'd0, 16'sd18);
        send_item(FUNC_TARGET, 2'd0, 16'sd100);
        repeat (4) step_raw(1'b1);
      end
      TRIP_CROSSED: begin
        send_item(FUNC_INIT, 2'd0, 16'sd0);
        send_item(FUNC_TARGET, 2'd0, 16'sd50);
        step_raw(1'($urandom));
      end
      TRIP_TOP_EDGE: begin
        send_item(FUNC_INIT, 2'd0, PosW'(PosMax));
        send_item(FUNC_TARGET, 2'd0, PosW'(PosMin));
        step_raw(1'b1);
      end
      default: begin
        send_item(FUNC_INIT, 2'd0, PosW'(PosMin));
        send_item(FUNC_TARGET, 2'd0, PosW'(PosMax));
        step_raw(1'b0);
      end
    endcase
    repeat (16) send_item(2'($urandom_range(0, 3)), 2'($urandom), 16'($urandom));
  endtask

  // Result side: ready runs and stalls of random length
  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
        hold = ($urandom_range(0, 99) < 2) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      end else begin
        hold = pick_idle_len();
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          hold--;
        end
      end
    end
  end

  function automatic void compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s expected %0h got %0h", name, want, got));
  endfunction

  // Compare each status transfer with the oldest expected one
  always @(posedge clk_i) begin : status_monitor
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (axis_status_q.size() == 0) begin
        report_error($sformatf("status %h with nothing expected", m_axis_tdata));
      end else begin
        want = axis_status_q.pop_front();
        compare_field("drive_left", 16'(got.drive_left), 16'(want.drive_left));
        compare_field("drive_right", 16'(got.drive_right), 16'(want.drive_right));
        compare_field("position", got.position, want.position);
        compare_field("moving", 16'(got.moving), 16'(want.moving));
        compare_field("fault", 16'(got.fault), 16'(want.fault));
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin : stall_watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("[encoder_axis_position_drive_unit] ERROR");
      $finish;
    end
  end

  initial begin : run_tests
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LOWER;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    prev_code     = 2'd0;
    track         = 0;
    goal          = 0;
    bound_lo      = int'(LowerBoundRst);
    bound_hi      = int'(UpperBoundRst);
    heading       = DIR_IDLE;
    left_lvl      = LevelOff;
    right_lvl     = LevelOff;
    latched       = FAULT_NONE;
    items_sent    = 0;
    error_cnt     = 0;
    send_burst    = 0;
    quiet_cycles  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_quadrature_steps();
    test_range_extremes();
    test_random_motion();
    test_fault_freeze();

    quiesce_axis();
    repeat (DrainCycles * 2) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("[encoder_axis_position_drive_unit] OK");
    end else begin
      $display("[encoder_axis_position_drive_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/epd_pkg.sv
sv/epd_core.sv
sv/epd_out_reg.sv
sv/encoder_axis_position_drive_unit.sv
sv/epd_checker.sv
bench/testbench.sv
